>>> hw/rtl/sil_pkg.sv
// Shared types and codes for the sorted insertion list.
`timescale 1ns / 1ps
package sil_pkg;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    write;         // store value_i this cycle
    logic    sorted;        // 1: sorted position, 0: tail
    logic    reply;         // emit a single result with reply_status
    status_e reply_status;
    logic    rd_step;       // emit the head entry and rotate the list
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic rd_last;          // the next read step emits the final entry
  } sts_t;

endpackage

>>> hw/rtl/sil_ctrl.sv
// Controller state machine for the sorted insertion list.
`timescale 1ns / 1ps
module sil_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [1:0]    operation_i,
  input  sil_pkg::sts_t sts_i,
  output sil_pkg::cmd_t cmd_o,
  output logic          busy_o
);
  import sil_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d            = state_q;
    cmd_o.write        = 1'b0;
    cmd_o.sorted       = 1'b0;
    cmd_o.reply        = 1'b0;
    cmd_o.reply_status = ST_OK;
    cmd_o.rd_step      = 1'b0;
    busy_o             = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (op_e'(operation_i))
            OP_APPEND, OP_INSERT: begin
              cmd_o.reply = 1'b1;
              if (sts_i.full) begin
                cmd_o.reply_status = ST_FULL;
              end else begin
                cmd_o.write  = 1'b1;
                cmd_o.sorted = (op_e'(operation_i) == OP_INSERT);
              end
            end
            OP_READ: begin
              if (sts_i.empty) begin
                cmd_o.reply        = 1'b1;
                cmd_o.reply_status = ST_EMPTY;
              end else begin
                state_d = S_READ;
              end
            end
            default: begin
              cmd_o.reply = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        busy_o        = 1'b1;
        cmd_o.rd_step = 1'b1;
        if (sts_i.rd_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/sil_datapath.sv
// Datapath for the sorted insertion list: entry cells, count and result register.
`timescale 1ns / 1ps
module sil_datapath #(
  parameter int DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sil_pkg::cmd_t      cmd_i,
  input  logic signed [31:0] value_i,
  output sil_pkg::sts_t      sts_o,
  output logic               valid_o,
  output logic signed [31:0] data_o,
  output logic [1:0]         status_o,
  output logic               last_o
);
  import sil_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic signed [31:0] cells_q [DEPTH];
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      rd_idx_q, rd_idx_d;
  logic               valid_q;
  logic signed [31:0] data_q;
  logic [1:0]         status_q;
  logic               last_q;

  logic [DEPTH-1:0] ins;    // candidate position for the new value
  logic [DEPTH-1:0] mark;   // at or after the insert position

  assign sts_o.empty   = (count_q == '0);
  assign sts_o.full    = (count_q == CW'(DEPTH));
  assign sts_o.rd_last = ((rd_idx_q + 1'b1) == count_q);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ins[i] = (CW'(i) == count_q) ||
               (cmd_i.sorted && (CW'(i) < count_q) && (cells_q[i] >= value_i));
    end
    mark[0] = ins[0];
    for (int i = 1; i < DEPTH; i++) begin
      mark[i] = mark[i-1] | ins[i];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (cmd_i.write) begin
        if (i > 0 && mark[i] && mark[(i > 0) ? i - 1 : 0]) begin
          cells_q[i] <= cells_q[(i > 0) ? i - 1 : 0];
        end else if (mark[i]) begin
          cells_q[i] <= value_i;
        end
      end else if (cmd_i.rd_step) begin
        // Rotate the stored part of the list left by one.
        if (CW'(i + 1) < count_q) begin
          cells_q[i] <= cells_q[(i + 1 < DEPTH) ? i + 1 : i];
        end else if (CW'(i + 1) == count_q) begin
          cells_q[i] <= cells_q[0];
        end
      end
    end
  end

  always_comb begin
    count_d  = count_q;
    rd_idx_d = rd_idx_q;
    if (cmd_i.write) begin
      count_d = count_q + 1'b1;
    end
    if (cmd_i.rd_step) begin
      rd_idx_d = sts_o.rd_last ? '0 : rd_idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rd_idx_q <= '0;
      valid_q  <= 1'b0;
    end else begin
      count_q  <= count_d;
      rd_idx_q <= rd_idx_d;
      valid_q  <= cmd_i.reply | cmd_i.rd_step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_step) begin
      data_q   <= cells_q[0];
      status_q <= ST_OK;
      last_q   <= sts_o.rd_last;
    end else begin
      data_q   <= '0;
      status_q <= cmd_i.reply_status;
      last_q   <= 1'b1;
    end
  end

  assign valid_o  = valid_q;
  assign data_o   = data_q;
  assign status_o = status_q;
  assign last_o   = last_q;

endmodule

>>> hw/rtl/sorted_insertion_list.sv
// Top level of the sorted insertion list: controller plus datapath.
`timescale 1ns / 1ps
// Ordered list of up to DEPTH signed 32-bit entries. An item is taken at a
// rising edge with start_i high and busy_o low. Append and sorted insert
// complete in the accepting cycle: all cells compare against value_i in
// parallel and shift in one step, so busy_o stays low and a new item may
// follow every cycle. A sorted insert goes before the first entry greater
// than or equal to the value. Read-out of a non-empty list holds busy_o high
// while the list rotates past its head cell and emits each entry in turn.
// Every result appears in the cycle after the work that caused it, on data_o,
// status_o and last_o, for exactly one cycle while valid_o is high; there is
// no backpressure, so the receiver must take each result as it comes.
// Status 1 refuses an append or insert into a full list, status 2 flags a
// read of an empty list; last_o marks the final result of each item.
module sorted_insertion_list #(
  parameter int DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         operation_i,
  input  logic signed [31:0] value_i,
  output logic               valid_o,
  output logic signed [31:0] data_o,
  output logic [1:0]         status_o,
  output logic               last_o
);
  import sil_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Decode the item and sequence read-out.
  sil_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .operation_i (operation_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy_o      (busy_o)
  );

  // Hold the entries and the result register.
  sil_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .value_i  (value_i),
    .sts_o    (sts),
    .valid_o  (valid_o),
    .data_o   (data_o),
    .status_o (status_o),
    .last_o   (last_o)
  );

endmodule

>>> sim/tb_sorted_insertion_list.sv
// Self-checking testbench for the sorted insertion list: directed table, then random items.
`timescale 1ns / 1ps
module tb_sorted_insertion_list;
  import sil_pkg::*;

  localparam int DEPTH = 16;
  localparam int IDLE_LIMIT = 400;
  localparam int RANDOM_ITEMS = 100;
  localparam int DRAIN_CYCLES = 4;
  // Operation code with no meaning: the block answers done and leaves the list alone.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic signed [31:0] data;
    status_e            status;
    logic               last;
  } list_result_t;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] value;
    logic               typed;   // 1: use want below instead of the mirror
    list_result_t       want;
  } stim_row_t;

  localparam list_result_t RES_DONE  = '{32'sd0, ST_OK, 1'b1};
  localparam list_result_t RES_FULL  = '{32'sd0, ST_FULL, 1'b1};
  localparam list_result_t RES_EMPTY = '{32'sd0, ST_EMPTY, 1'b1};

  localparam int N_ROWS = 23;
  stim_row_t directed_rows [N_ROWS] = '{
    '{OP_READ,   32'sd0,            1'b1, RES_EMPTY},  // read right after reset
    '{OP_UNUSED, 32'sd0,            1'b1, RES_DONE},
    '{OP_APPEND, VAL_MAX,           1'b1, RES_DONE},
    '{OP_INSERT, VAL_MIN,           1'b1, RES_DONE},
    '{OP_INSERT, 32'sd0,            1'b0, RES_DONE},
    '{OP_INSERT, VAL_MAX,           1'b0, RES_DONE},   // equal to the tail
    '{OP_INSERT, VAL_MIN,           1'b0, RES_DONE},   // equal to the head
    '{OP_APPEND, -32'sd1,           1'b0, RES_DONE},   // append breaks the order
    '{OP_INSERT, 32'sd5,            1'b0, RES_DONE},
    '{OP_READ,   32'sd0,            1'b0, RES_DONE},
    '{OP_INSERT, 32'sh5555_5555,    1'b0, RES_DONE},
    '{OP_INSERT, 32'shAAAA_AAAA,    1'b0, RES_DONE},
    '{OP_APPEND, 32'sd0,            1'b0, RES_DONE},
    '{OP_INSERT, 32'sd5,            1'b0, RES_DONE},   // equal in the middle
    '{OP_INSERT, -32'sd1,           1'b0, RES_DONE},
    '{OP_APPEND, 32'sd1,            1'b0, RES_DONE},
    '{OP_INSERT, 32'shFFFF_FFFE,    1'b0, RES_DONE},
    '{OP_INSERT, 32'sh7FFF_FFFE,    1'b0, RES_DONE},
    '{OP_INSERT, 32'sd3,            1'b0, RES_DONE},   // list now full
    '{OP_INSERT, 32'sd0,            1'b1, RES_FULL},
    '{OP_APPEND, 32'sd1,            1'b1, RES_FULL},
    '{OP_UNUSED, VAL_MAX,           1'b1, RES_DONE},
    '{OP_READ,   VAL_MIN,           1'b0, RES_DONE}    // full read-out
  };

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [1:0]         operation_i = OP_APPEND;
  logic signed [31:0] value_i = 32'sd0;
  logic               valid_o;
  logic signed [31:0] data_o;
  logic [1:0]         status_o;
  logic               last_o;

  sorted_insertion_list #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .operation_i(operation_i),
    .value_i    (value_i),
    .valid_o    (valid_o),
    .data_o     (data_o),
    .status_o   (status_o),
    .last_o     (last_o)
  );

  always #6 clk_i = ~clk_i;

  // Mirror of the list contents and the results still owed by the block.
  logic signed [31:0] mirror_entries [DEPTH];
  int                 mirror_count = 0;
  list_result_t       pending_results [$];
  int                 err_count = 0;
  bit                 burst_mode = 1'b0;
  int                 idle_cycles = 0;

  // Apply one operation to the mirror and queue the results it causes.
  function automatic void predict_list_op(input logic [1:0] op,
                                          input logic signed [31:0] val);
    int           pos;
    list_result_t res;
    res = RES_DONE;
    if (op == OP_READ) begin
      if (mirror_count == 0) begin
        pending_results.push_back(RES_EMPTY);
      end else begin
        for (int i = 0; i < mirror_count; i++) begin
          res.data = mirror_entries[i];
          res.last = (i == mirror_count - 1);
          pending_results.push_back(res);
        end
      end
    end else if (op != OP_APPEND && op != OP_INSERT) begin
      pending_results.push_back(RES_DONE);
    end else if (mirror_count >= DEPTH) begin
      pending_results.push_back(RES_FULL);
    end else begin
      pos = mirror_count;
      if (op == OP_INSERT) begin
        for (int i = 0; i < mirror_count; i++) begin
          if (mirror_entries[i] >= val) begin
            pos = i;
            break;
          end
        end
      end
      for (int i = mirror_count; i > pos; i--) mirror_entries[i] = mirror_entries[i - 1];
      mirror_entries[pos] = val;
      mirror_count++;
      pending_results.push_back(RES_DONE);
    end
  endfunction

  // Offer one item, after a random gap unless in burst mode, and hold it until the block takes it.
  task automatic send_item(input logic [1:0] op, input logic signed [31:0] val,
                           input logic typed, input list_result_t want);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i     <= 1'b1;
    operation_i <= op;
    value_i     <= val;
    do @(posedge clk_i); while (busy_o);
    predict_list_op(op, val);
    // Typed rows carry their own single expectation.
    if (typed) begin
      void'(pending_results.pop_back());
      pending_results.push_back(want);
    end
  endtask

  // Lower start and hold until every owed result has come back.
  task automatic drain_results();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // Compare each result against the oldest expectation.
  always @(posedge clk_i) begin
    list_result_t exp_r;
    if (rst_ni && valid_o) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: data %0d status %0d last %0b",
               data_o, status_o, last_o);
        err_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (data_o !== exp_r.data) begin
          $error("data: expected %0d, got %0d", exp_r.data, data_o);
          err_count++;
        end
        if (status_o !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, status_o);
          err_count++;
        end
        if (last_o !== exp_r.last) begin
          $error("last: expected %0b, got %0b", exp_r.last, last_o);
          err_count++;
        end
      end
    end
  end

  // Watchdog: count cycles in which neither an item nor a result moves.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || valid_o) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [1:0]         op;
    logic signed [31:0] val;
    int                 pick;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: first stretch back to back, the rest with gaps.
    for (int r = 0; r < N_ROWS; r++) begin
      burst_mode = (r < 8);
      send_item(directed_rows[r].op, directed_rows[r].value,
                directed_rows[r].typed, directed_rows[r].want);
    end
    drain_results();

    // Random items: alternate stretches of gaps and back-to-back offers.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      burst_mode = ((n / 10) % 3 == 0);
      if (n == RANDOM_ITEMS / 2) drain_results();
      pick = $urandom_range(0, 9);
      if (pick < 4) op = OP_INSERT;
      else if (pick < 6) op = OP_APPEND;
      else if (pick < 9) op = OP_READ;
      else op = OP_UNUSED;
      if ($urandom_range(0, 1)) val = $urandom;
      else val = $signed($urandom_range(0, 8)) - 32'sd4;
      send_item(op, val, 1'b0, RES_DONE);
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/sil_pkg.sv
hw/rtl/sil_ctrl.sv
hw/rtl/sil_datapath.sv
hw/rtl/sorted_insertion_list.sv
sim/tb_sorted_insertion_list.sv
